>>> hdl/gop_pkg.sv
package gop_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_PRICE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIKE_PRICE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BARRIER_LEVEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_DRIFT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_VOL       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SQRT_DT       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_OPTION_SETUP  = 3'd7;

  // Payoff kinds in option_setup[1:0].
  localparam logic [1:0] MODE_EURO  = 2'd0;
  localparam logic [1:0] MODE_ASIAN = 2'd1;
  localparam logic [1:0] MODE_UPOUT = 2'd2;
  localparam logic [1:0] MODE_ZERO  = 2'd3;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [40:0] CAP40     = 41'h100_0000_0000;
  localparam logic [47:0] SUM_MAX   = 48'hFFFF_FFFF_FFFF;
  localparam logic [3:0]  TAYLOR_TERMS = 4'd12;

  // Shared divider.
  localparam int DIV_W     = 64;
  localparam int DVSR_W    = 40;
  localparam int DIV_CNT_W = 7;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // floor(2^32 / k) for the series terms; the product with it is at most one low.
  function automatic logic [32:0] recip_k(input logic [3:0] k);
    logic [32:0] r;
    unique case (k)
      4'd1:    r = 33'd4294967296;
      4'd2:    r = 33'd2147483648;
      4'd3:    r = 33'd1431655765;
      4'd4:    r = 33'd1073741824;
      4'd5:    r = 33'd858993459;
      4'd6:    r = 33'd715827882;
      4'd7:    r = 33'd613566756;
      4'd8:    r = 33'd536870912;
      4'd9:    r = 33'd477218588;
      4'd10:   r = 33'd429496729;
      4'd11:   r = 33'd390451572;
      4'd12:   r = 33'd357913941;
      default: r = 33'd0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/gop_div.sv
module gop_div (
  input  logic              clk,
  input  logic              rst_n,
  input  gop_pkg::div_req_t req,
  output gop_pkg::div_rsp_t rsp
);
  import gop_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DVSR_W:0]      rem_r;
  logic [DIV_W-1:0]     quo_r;
  logic [DVSR_W-1:0]    dvsr_r;
  logic [DVSR_W:0]      rem_sh;
  logic                 ge;

  // Restoring division, one quotient bit per cycle; the dividend shifts out
  // of quo_r as the quotient shifts in.
  assign rem_sh = {rem_r[DVSR_W-1:0], quo_r[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, dvsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= '0;
      quo_r  <= req.dividend;
      dvsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? (rem_sh - {1'b0, dvsr_r}) : rem_sh;
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

>>> hdl/gbm_option_path_engine_top.sv
// Each time step holds ready low from acceptance until the step is done, so a new sample is
// taken only once the last one is through: one shared 34x34 multiplier runs a twelve-term
// exponential series per path. The last step of a path then forms the result through the
// shared divider (two means, and for a European payoff two deltas as well), plus any wait
// for the output register. Reset is synchronous, active low: it loads the register defaults,
// clears the path state and empties the output register.
module gbm_option_path_engine_top #(
  parameter int STEP_COUNT_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // normal_sample
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // path_payoff, control_value, delta_sample, vega_sample
  output logic [127:0]                    out_tdata,
  output logic                            out_tuser,  // greeks_valid
  input  logic                            cfg_wr_en,
  input  logic [gop_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [31:0]                     cfg_wdata
);
  import gop_pkg::*;

  localparam logic [STEP_COUNT_WIDTH-1:0] CNT_MAX = '1;

  typedef enum logic [5:0] {
    S_IDLE, S_VZ, S_BM, S_XA, S_XB, S_YH, S_YL, S_Y, S_U, S_TAY0,
    S_TM, S_TR, S_TC, S_P, S_PS,
    S_MA_GO, S_MA_W, S_MB_GO, S_MB_W, S_PP, S_PPR, S_CV,
    S_DA, S_DA_GO, S_DA_W, S_DB, S_DB_GO, S_DB_W,
    S_VT0, S_VT1, S_VT2, S_VH, S_VL, S_VC, S_FIN, S_EMIT
  } state_t;

  state_t state_r;

  // Configuration.
  logic [31:0] start_price_r, strike_r, barrier_r, drift_r, discount_r;
  logic [30:0] log_vol_r, sqrt_dt_r;
  logic [2:0]  setup_r;

  // Path state.
  logic [31:0]                 price_a_r, price_b_r;
  logic [47:0]                 sum_a_r, sum_b_r;
  logic                        knocked_a_r, knocked_b_r;
  logic signed [39:0]          bm_r;
  logic [STEP_COUNT_WIDTH-1:0] cnt_r;

  // Step work registers.
  logic signed [15:0] z_r;
  logic               last_r;
  logic               path_r;
  logic signed [34:0] vz_r;
  logic signed [35:0] x_r;
  logic signed [52:0] yh_r;
  logic signed [7:0]  n_r;
  logic [29:0]        f_r;
  logic [29:0]        u_r;
  logic [30:0]        r_r;
  logic [30:0]        t_r;
  logic [3:0]         k_r;

  // Result work registers.
  logic [31:0]        mean_a_r, mean_b_r, payoff_r, control_r;
  logic [32:0]        dp_a_r, dp_b_r;
  logic [63:0]        da_r, db_r;
  logic [45:0]        volt_r;
  logic [57:0]        hi_r;
  logic signed [41:0] va_r, vb_r;
  logic [31:0]        delta_r, vega_r;

  logic         out_valid_r;
  logic [127:0] out_data_r;
  logic         out_user_r;

  // Shared multiplier.
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  gop_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  function automatic logic [31:0] sat32(input logic [64:0] v);
    return (v > 65'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] payoff_of(input logic [31:0] st, input logic [31:0] mean,
                                            input logic knocked, input logic [1:0] mode,
                                            input logic [31:0] strike);
    logic [31:0] base;
    base = (mode == MODE_ASIAN) ? mean : st;
    if (mode == MODE_ZERO || (mode == MODE_UPOUT && knocked)) return 32'd0;
    return (base > strike) ? base - strike : 32'd0;
  endfunction

  logic [1:0]  mode;
  logic        anti;
  logic [31:0] pay_a, pay_b, price_cur;
  logic [32:0] pay_sum, ctl_sum;
  logic [33:0] pair_sum;

  assign mode      = setup_r[1:0];
  assign anti      = setup_r[2];
  assign price_cur = path_r ? price_b_r : price_a_r;
  assign pay_a     = payoff_of(price_a_r, mean_a_r, knocked_a_r, mode, strike_r);
  assign pay_b     = payoff_of(price_b_r, mean_b_r, knocked_b_r, mode, strike_r);
  assign pay_sum   = {1'b0, pay_a} + {1'b0, (anti ? pay_b : pay_a)};
  assign ctl_sum   = {1'b0, price_a_r} + {1'b0, (anti ? price_b_r : price_a_r)};
  // Pair value: discount times the 33-bit sum, top bit handled as a plain add.
  assign pair_sum  = ((state_r == S_PPR ? pay_sum[32] : ctl_sum[32]) ? {2'b0, discount_r} : 34'd0)
                   + {2'b0, mul_r[63:32]};

  // Series step: t = u*r/2^30, then t/k through the reciprocal and one fix-up.
  logic [35:0] qk, t_rem;
  logic [30:0] q0, q;
  assign q0    = mul_r[62:32];
  assign qk    = {5'b0, q0} * {32'b0, k_r};
  assign t_rem = {5'b0, t_r} - qk;
  assign q     = (t_rem >= {32'b0, k_r}) ? q0 + 31'd1 : q0;

  // Price update: product shifted by 30 - n and saturated.
  logic signed [9:0] sh;
  logic [62:0]       prod, shifted;
  logic [31:0]       new_price;
  logic [48:0]       sum_add;
  logic [47:0]       sum_cur;
  assign sh      = 10'sd30 - {{2{n_r[7]}}, n_r};
  assign prod    = mul_r[62:0];
  assign shifted = prod >> sh[5:0];
  always_comb begin
    if (sh >= 10'sd64)    new_price = 32'd0;
    else if (sh < 10'sd0) new_price = (prod != 63'd0) ? 32'hFFFF_FFFF : 32'd0;
    else                  new_price = sat32({2'b0, shifted});
  end
  assign sum_cur = path_r ? sum_b_r : sum_a_r;
  assign sum_add = {1'b0, sum_cur} + {17'b0, new_price};

  // Brownian sum update.
  logic signed [24:0] bm_inc;
  logic signed [40:0] bm_sum;
  logic signed [39:0] bm_new;
  assign bm_inc = $signed(mul_r[46:22]);
  assign bm_sum = 41'(bm_r) + 41'(bm_inc);
  always_comb begin
    if (bm_sum > 41'sh7F_FFFF_FFFF)       bm_new = 40'sh7F_FFFF_FFFF;
    else if (bm_sum < -41'sh80_0000_0000) bm_new = -40'sh80_0000_0000;
    else                                  bm_new = bm_sum[39:0];
  end

  logic signed [52:0] y_sum;
  assign y_sum = yh_r + $signed({22'b0, mul_r[45:15]});

  // Vega term for the current path.
  logic signed [48:0] w49, vt49, term;
  logic [48:0]        mag;
  logic [32:0]        dp_cur;
  logic [44:0]        vr;
  logic [40:0]        vmag;
  logic signed [41:0] vsigned;
  assign w49    = 49'(bm_r);
  assign vt49   = {3'b0, volt_r};
  assign term   = path_r ? (-w49 - vt49) : (w49 - vt49);
  assign mag    = term[48] ? 49'(-term) : term;
  assign dp_cur = path_r ? dp_b_r : dp_a_r;
  assign vr     = {1'b0, hi_r[39:0], 4'b0} + {8'b0, mul_r[56:20]};
  always_comb begin
    if (hi_r >= {17'b0, CAP40} || vr > {4'b0, CAP40}) vmag = CAP40;
    else                                              vmag = vr[40:0];
    if (!(price_cur > strike_r)) vsigned = '0;
    else if (term[48])           vsigned = -$signed({1'b0, vmag});
    else                         vsigned = $signed({1'b0, vmag});
  end

  logic [64:0]        dsum;
  logic signed [42:0] vsum;
  logic signed [41:0] vhalf;
  assign dsum  = {1'b0, da_r} + {1'b0, db_r};
  assign vsum  = 43'(va_r) + 43'(vb_r);
  assign vhalf = anti ? vsum[42:1] : va_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_VZ:  begin mul_a = {3'b0, log_vol_r};  mul_b = 34'(z_r); end
      S_BM:  begin mul_a = 34'(z_r);           mul_b = {3'b0, sqrt_dt_r}; end
      S_YH:  begin mul_a = 34'($signed(x_r[35:15])); mul_b = {3'b0, LOG2E_Q30}; end
      S_YL:  begin mul_a = {19'b0, x_r[14:0]}; mul_b = {3'b0, LOG2E_Q30}; end
      S_U:   begin mul_a = {4'b0, f_r};        mul_b = {4'b0, LN2_Q30}; end
      S_TM:  begin mul_a = {4'b0, u_r};        mul_b = {3'b0, r_r}; end
      S_TR:  begin mul_a = {3'b0, mul_r[60:30]}; mul_b = {1'b0, recip_k(k_r)}; end
      S_P:   begin mul_a = {2'b0, price_cur};  mul_b = {3'b0, r_r}; end
      S_PP:  begin mul_a = {2'b0, discount_r}; mul_b = {2'b0, pay_sum[31:0]}; end
      S_PPR: begin mul_a = {2'b0, discount_r}; mul_b = {2'b0, ctl_sum[31:0]}; end
      S_DA:  begin mul_a = {2'b0, discount_r}; mul_b = {2'b0, price_a_r}; end
      S_DB:  begin mul_a = {2'b0, discount_r}; mul_b = {2'b0, price_b_r}; end
      S_VT0: begin mul_a = {3'b0, log_vol_r};  mul_b = {3'b0, sqrt_dt_r}; end
      S_VT1: begin
        mul_a = {2'b0, mul_r[61:30]};
        mul_b = {{(34-STEP_COUNT_WIDTH){1'b0}}, cnt_r};
      end
      S_VH:  begin mul_a = {1'b0, dp_cur};     mul_b = {9'b0, mag[48:24]}; end
      S_VL:  begin mul_a = {1'b0, dp_cur};     mul_b = {10'b0, mag[23:0]}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {16'b0, sum_a_r};
    div_req.divisor  = {{(DVSR_W-STEP_COUNT_WIDTH){1'b0}}, cnt_r};
    unique case (state_r)
      S_MA_GO: div_req.start = 1'b1;
      S_MB_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {16'b0, sum_b_r};
      end
      S_DA_GO, S_DB_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = mul_r[63:0];
        div_req.divisor  = {1'b0, start_price_r, 7'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      start_price_r <= 32'd6553600;
      strike_r      <= 32'd6553600;
      barrier_r     <= 32'hFFFF_FFFF;
      drift_r       <= '0;
      log_vol_r     <= '0;
      sqrt_dt_r     <= '0;
      discount_r    <= 32'h8000_0000;
      setup_r       <= '0;
      sum_a_r       <= '0;
      sum_b_r       <= '0;
      knocked_a_r   <= 1'b0;
      knocked_b_r   <= 1'b0;
      bm_r          <= '0;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          CFG_START_PRICE:   start_price_r <= cfg_wdata;
          CFG_STRIKE_PRICE:  strike_r      <= cfg_wdata;
          CFG_BARRIER_LEVEL: barrier_r     <= cfg_wdata;
          CFG_LOG_DRIFT:     drift_r       <= cfg_wdata;
          CFG_LOG_VOL:       log_vol_r     <= cfg_wdata[30:0];
          CFG_SQRT_DT:       sqrt_dt_r     <= cfg_wdata[30:0];
          CFG_DISCOUNT:      discount_r    <= cfg_wdata;
          CFG_OPTION_SETUP:  setup_r       <= cfg_wdata[2:0];
        endcase
      end
      if (out_valid_r && out_tready && state_r != S_EMIT) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            z_r    <= $signed(in_tdata);
            last_r <= in_tlast;
            if (cnt_r == '0) begin
              price_a_r <= start_price_r;
              price_b_r <= start_price_r;
            end
            state_r <= S_VZ;
          end
        end
        S_VZ: state_r <= S_BM;
        S_BM: begin
          vz_r    <= $signed(mul_r[46:12]);
          state_r <= S_XA;
        end
        S_XA: begin
          bm_r    <= bm_new;
          x_r     <= 36'($signed(drift_r)) + 36'(vz_r);
          path_r  <= 1'b0;
          state_r <= S_YH;
        end
        S_XB: begin
          x_r     <= 36'($signed(drift_r)) - 36'(vz_r);
          path_r  <= 1'b1;
          state_r <= S_YH;
        end
        S_YH: state_r <= S_YL;
        S_YL: begin
          yh_r    <= mul_r[52:0];
          state_r <= S_Y;
        end
        S_Y: begin
          n_r     <= $signed(y_sum[52:45]);
          f_r     <= y_sum[44:15];
          state_r <= S_U;
        end
        S_U: state_r <= S_TAY0;
        S_TAY0: begin
          u_r     <= mul_r[59:30];
          r_r     <= ONE_Q30;
          k_r     <= TAYLOR_TERMS;
          state_r <= S_TM;
        end
        S_TM: state_r <= S_TR;
        S_TR: begin
          t_r     <= mul_r[60:30];
          state_r <= S_TC;
        end
        S_TC: begin
          r_r <= ONE_Q30 + q;
          k_r <= k_r - 4'd1;
          state_r <= (k_r == 4'd1) ? S_P : S_TM;
        end
        S_P: state_r <= S_PS;
        S_PS: begin
          if (path_r) begin
            price_b_r   <= new_price;
            sum_b_r     <= sum_add[48] ? SUM_MAX : sum_add[47:0];
            knocked_b_r <= knocked_b_r || (new_price >= barrier_r);
            if (cnt_r != CNT_MAX) cnt_r <= cnt_r + 1'b1;
            state_r <= last_r ? S_MA_GO : S_IDLE;
          end else begin
            price_a_r   <= new_price;
            sum_a_r     <= sum_add[48] ? SUM_MAX : sum_add[47:0];
            knocked_a_r <= knocked_a_r || (new_price >= barrier_r);
            state_r     <= S_XB;
          end
        end
        S_MA_GO: state_r <= S_MA_W;
        S_MA_W: begin
          if (div_rsp.done) begin
            mean_a_r <= sat32({1'b0, div_rsp.quotient});
            state_r  <= S_MB_GO;
          end
        end
        S_MB_GO: state_r <= S_MB_W;
        S_MB_W: begin
          if (div_rsp.done) begin
            mean_b_r <= sat32({1'b0, div_rsp.quotient});
            state_r  <= S_PP;
          end
        end
        S_PP: state_r <= S_PPR;
        S_PPR: begin
          payoff_r <= sat32({31'b0, pair_sum});
          state_r  <= S_CV;
        end
        S_CV: begin
          control_r <= sat32({31'b0, pair_sum});
          state_r   <= (mode == MODE_EURO) ? S_DA : S_FIN;
        end
        S_DA: state_r <= S_DA_GO;
        S_DA_GO: begin
          dp_a_r  <= mul_r[63:31];
          state_r <= S_DA_W;
        end
        S_DA_W: begin
          if (div_rsp.done) begin
            if (!(price_a_r > strike_r))   da_r <= '0;
            else if (start_price_r == '0) da_r <= {23'b0, CAP40};
            else                          da_r <= div_rsp.quotient;
            state_r <= S_DB;
          end
        end
        S_DB: state_r <= S_DB_GO;
        S_DB_GO: begin
          dp_b_r  <= mul_r[63:31];
          state_r <= S_DB_W;
        end
        S_DB_W: begin
          if (div_rsp.done) begin
            if (!(price_b_r > strike_r))   db_r <= '0;
            else if (start_price_r == '0) db_r <= {23'b0, CAP40};
            else                          db_r <= div_rsp.quotient;
            state_r <= S_VT0;
          end
        end
        S_VT0: state_r <= S_VT1;
        S_VT1: state_r <= S_VT2;
        S_VT2: begin
          volt_r  <= mul_r[55:10];
          path_r  <= 1'b0;
          state_r <= S_VH;
        end
        S_VH: state_r <= S_VL;
        S_VL: begin
          hi_r    <= mul_r[57:0];
          state_r <= S_VC;
        end
        S_VC: begin
          if (path_r) begin
            vb_r    <= vsigned;
            state_r <= S_FIN;
          end else begin
            va_r    <= vsigned;
            path_r  <= 1'b1;
            state_r <= S_VH;
          end
        end
        S_FIN: begin
          if (mode == MODE_EURO) begin
            delta_r <= anti ? sat32({1'b0, dsum[64:1]}) : sat32({1'b0, da_r});
            if (vhalf > 42'sh0_7FFF_FFFF)       vega_r <= 32'h7FFF_FFFF;
            else if (vhalf < -42'sh0_8000_0000) vega_r <= 32'h8000_0000;
            else                                vega_r <= vhalf[31:0];
          end else begin
            delta_r <= '0;
            vega_r  <= '0;
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {vega_r, delta_r, control_r, payoff_r};
            out_user_r  <= (mode == MODE_EURO);
            sum_a_r     <= '0;
            sum_b_r     <= '0;
            knocked_a_r <= 1'b0;
            knocked_b_r <= 1'b0;
            bm_r        <= '0;
            cnt_r       <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  // A result appears only when the emit state hands one over.
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result appeared outside the emit state");

  // The divider is never restarted while a division runs.
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // A new beat is never taken while the divider still works.
  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_rsp.busy)
    else $error("input ready while divider busy");
`endif

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import gop_pkg::*;

  typedef struct {
    logic [31:0] payoff;
    logic [31:0] control;
    logic [31:0] delta;
    logic [31:0] vega;
    logic        greeks;
  } path_result_t;

  class option_path_scoreboard;
    localparam longint L2E = 64'sd1549082005;
    localparam longint LN2 = 64'sd744261118;
    localparam longint ONE = 64'sd1073741824;
    localparam longint BM_MAX = 64'sd549755813887;
    localparam logic [63:0] CAP = 64'h100_0000_0000;
    localparam int CNT_MAX = 65535;

    logic [31:0] start_px, strike_px, barrier_px, drift_q30, discount_q31;
    logic [30:0] vol_q30, sqrtdt_q30;
    logic [2:0]  setup;
    logic [31:0] px_a, px_b;
    logic [63:0] sum_a, sum_b;
    logic        knock_a, knock_b;
    longint      bm_sum;
    int          steps;
    path_result_t pending_q[$];
    int          mismatches;
    int          results_seen;
    int          steps_seen;

    function void reset_all();
      start_px = 6553600;
      strike_px = 6553600;
      barrier_px = 32'hFFFF_FFFF;
      drift_q30 = 0;
      vol_q30 = 0;
      sqrtdt_q30 = 0;
      discount_q31 = 32'h8000_0000;
      setup = 0;
      clear_path();
    endfunction

    function void clear_path();
      px_a = start_px;
      px_b = start_px;
      sum_a = 0;
      sum_b = 0;
      knock_a = 0;
      knock_b = 0;
      bm_sum = 0;
      steps = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        CFG_START_PRICE:   start_px = val;
        CFG_STRIKE_PRICE:  strike_px = val;
        CFG_BARRIER_LEVEL: barrier_px = val;
        CFG_LOG_DRIFT:     drift_q30 = val;
        CFG_LOG_VOL:       vol_q30 = val[30:0];
        CFG_SQRT_DT:       sqrtdt_q30 = val[30:0];
        CFG_DISCOUNT:      discount_q31 = val;
        CFG_OPTION_SETUP:  setup = val[2:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] sat32(logic [63:0] v);
      return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // One step of price * exp(x), x in Q30, via 2^n * exp(frac * ln2).
    function logic [31:0] grow(logic [31:0] p, longint x);
      longint xh, xl, y, n, f, u, r, s;
      logic [63:0] prod;
      xh = x >>> 15;
      xl = x & longint'(64'h7FFF);
      y = (xh * L2E + ((xl * L2E) >>> 15)) >>> 15;
      n = y >>> 30;
      f = y & longint'(64'h3FFF_FFFF);
      u = (f * LN2) >>> 30;
      r = ONE;
      for (int k = 12; k >= 1; k--) r = ONE + ((u * r) >>> 30) / k;
      prod = 64'(p) * 64'(r);
      s = 30 - n;
      if (s >= 64) return 0;
      if (s < 0) return (prod != 0) ? 32'hFFFF_FFFF : 32'd0;
      return sat32(prod >> s);
    endfunction

    function logic [31:0] discounted_pair(logic [31:0] a, logic [31:0] b);
      logic [63:0] t, v;
      t = 64'(a) + 64'(b);
      v = 64'(discount_q31) * (t >> 32) + ((64'(discount_q31) * (t & 64'hFFFF_FFFF)) >> 32);
      return sat32(v);
    endfunction

    function logic [63:0] delta_of(logic [31:0] st);
      if (!(st > strike_px)) return 0;
      if (start_px == 0) return CAP;
      return (64'(discount_q31) * 64'(st)) / (64'(start_px) * 64'd128);
    endfunction

    function longint vega_of(logic [31:0] st, longint term);
      logic [63:0] dp, mag, th, tl, hi, r;
      if (!(st > strike_px)) return 0;
      dp = (64'(discount_q31) * 64'(st)) >> 31;
      mag = (term < 0) ? 64'(-term) : 64'(term);
      th = mag >> 24;
      tl = mag & 64'hFF_FFFF;
      hi = dp * th;
      if (hi >= CAP) r = CAP;
      else r = (hi << 4) + ((dp * tl) >> 20);
      if (r > CAP) r = CAP;
      return (term < 0) ? -longint'(r) : longint'(r);
    endfunction

    function logic [31:0] payoff_of(logic [31:0] st, logic [31:0] avg, logic knocked,
                                    logic [1:0] mode);
      logic [31:0] base;
      base = (mode == MODE_ASIAN) ? avg : st;
      if (mode == MODE_ZERO || (mode == MODE_UPOUT && knocked)) return 0;
      return (base > strike_px) ? base - strike_px : 32'd0;
    endfunction

    function void note_step(logic signed [15:0] z_in, logic last);
      longint z, vz, w, vol_t, va, vb, v;
      logic [63:0] da, db;
      logic [31:0] avg_a, avg_b, pay_a, pay_b;
      logic [1:0] mode;
      logic anti;
      path_result_t res;
      z = z_in;
      steps_seen++;
      if (steps == 0) begin
        px_a = start_px;
        px_b = start_px;
      end
      vz = (longint'(vol_q30) * z) >>> 12;
      px_a = grow(px_a, longint'($signed(drift_q30)) + vz);
      px_b = grow(px_b, longint'($signed(drift_q30)) - vz);
      bm_sum += (z * longint'(sqrtdt_q30)) >>> 22;
      if (bm_sum > BM_MAX) bm_sum = BM_MAX;
      if (bm_sum < -BM_MAX - 1) bm_sum = -BM_MAX - 1;
      sum_a += px_a;
      if (sum_a > SUM_MAX) sum_a = SUM_MAX;
      sum_b += px_b;
      if (sum_b > SUM_MAX) sum_b = SUM_MAX;
      knock_a |= (px_a >= barrier_px);
      knock_b |= (px_b >= barrier_px);
      if (steps < CNT_MAX) steps++;
      if (!last) return;
      mode = setup[1:0];
      anti = setup[2];
      avg_a = sat32(sum_a / 64'(steps));
      avg_b = sat32(sum_b / 64'(steps));
      pay_a = payoff_of(px_a, avg_a, knock_a, mode);
      pay_b = payoff_of(px_b, avg_b, knock_b, mode);
      res.payoff = anti ? discounted_pair(pay_a, pay_b) : discounted_pair(pay_a, pay_a);
      res.control = anti ? discounted_pair(px_a, px_b) : discounted_pair(px_a, px_a);
      if (mode == MODE_EURO) begin
        w = bm_sum;
        vol_t = longint'((((64'(vol_q30) * 64'(sqrtdt_q30)) >> 30) * 64'(steps)) >> 10);
        da = delta_of(px_a);
        db = delta_of(px_b);
        res.delta = anti ? sat32((da + db) >> 1) : sat32(da);
        va = vega_of(px_a, w - vol_t);
        vb = vega_of(px_b, -w - vol_t);
        v = anti ? (va + vb) >>> 1 : va;
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        res.vega = v[31:0];
        res.greeks = 1;
      end else begin
        res.delta = 0;
        res.vega = 0;
        res.greeks = 0;
      end
      pending_q.push_back(res);
      clear_path();
    endfunction

    function void report(string what, logic [31:0] exp_v, logic [31:0] act_v);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s in result %0d: expected %h, got %h",
                 what, results_seen, exp_v, act_v);
    endfunction

    function void check_result(logic [127:0] data, logic flag);
      path_result_t e;
      results_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %h", data);
        return;
      end
      e = pending_q.pop_front();
      if (data[31:0] !== e.payoff) report("path_payoff", e.payoff, data[31:0]);
      if (data[63:32] !== e.control) report("control_value", e.control, data[63:32]);
      if (data[95:64] !== e.delta) report("delta_sample", e.delta, data[95:64]);
      if (data[127:96] !== e.vega) report("vega_sample", e.vega, data[127:96]);
      if (flag !== e.greeks) report("greeks_valid", 32'(e.greeks), 32'(flag));
    endfunction
  endclass

  localparam int IDLE_LIMIT = 10000;
  localparam int SETTLE_CYCLES = 400;
  localparam int NUM_PHASES = 12;
  localparam int STEPS_PER_PHASE = 58;

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tlast;
  logic [15:0] in_tdata;
  logic out_tvalid, out_tready, out_tuser;
  logic [127:0] out_tdata;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [31:0] cfg_wdata;

  option_path_scoreboard sb;
  bit calm;
  bit long_hold;
  int idle_cycles;

  gbm_option_path_engine_top dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    if (rst_n && ((out_tvalid && out_tready) || (in_tvalid && in_tready)))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: short random stalls, plus one long hold-off on request.
  initial begin
    out_tready <= 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_tready <= 0;
        repeat (2000) @(posedge clk);
        long_hold = 0;
        out_tready <= 1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_tready <= 1;
      end else begin
        out_tready <= 1;
      end
    end
  end

  task automatic send_step(logic [15:0] z, logic last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= z;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_step(z, last);
  endtask

  task automatic program_regs(logic [31:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_wr_en <= 1;
      cfg_addr <= CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.write_reg(CFG_IDX_W'(i), vals[i]);
    end
    cfg_wr_en <= 0;
  endtask

  task automatic drain_and_settle();
    in_tvalid <= 0;
    while (sb.pending_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] draw_sample();
    if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 65535));
    return 16'($signed($urandom_range(0, 16384)) - 8192);
  endfunction

  function automatic void phase_regs(int p, output logic [31:0] v [8]);
    // Typical market values: 100.0 start and strike, sigma about 0.2 over 50 steps.
    v = '{32'd6553600, 32'd6553600, 32'hFFFF_FFFF, 32'd644245,
          32'd30370000, 32'd151850000, 32'd2040109465, 32'(MODE_EURO)};
    case (p)
      0: ;
      1: v[7] = {29'd0, 1'b1, MODE_EURO};
      2: begin v[7] = 32'(MODE_ASIAN); v[4] = 32'd120000000; end
      3: begin v[2] = 32'd6900000; v[7] = {29'd0, 1'b1, MODE_UPOUT}; end
      4: v[7] = {29'd0, 1'b1, MODE_ZERO};
      5: begin v[0] = 0; v[1] = 0; v[7] = {29'd0, 1'b1, MODE_EURO}; end
      6: v = '{32'hFFFF_FFFF, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'hFFFF_FFFF, {29'd0, 1'b1, MODE_EURO}};
      7: v = '{32'd1, 32'd0, 32'd0, 32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'(MODE_EURO)};
      default: begin
        for (int i = 0; i < 8; i++) v[i] = $urandom;
        if ($urandom_range(0, 1)) begin
          v[0] = $urandom_range(65536, 32'h0100_0000);
          v[1] = v[0] + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
          v[3] = $urandom_range(0, 4000000) - 2000000;
          v[4] = $urandom_range(0, 300000000);
        end
      end
    endcase
  endfunction

  initial begin
    logic [31:0] regs [8];
    logic [15:0] edge_z [8];
    int sent, len;
    sb = new();
    sb.reset_all();
    rst_n <= 0;
    in_tvalid <= 0;
    in_tdata <= 0;
    in_tlast <= 0;
    cfg_wr_en <= 0;
    cfg_addr <= '0;
    cfg_wdata <= 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    edge_z = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h1000, 16'hF000, 16'h5555};

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 2) calm = 1;
      // Phase two ends mid path, so the next payoff kind applies to a path
      // that began under the old one.
      if (p != 3) drain_and_settle();
      else begin
        in_tvalid <= 0;
        repeat (SETTLE_CYCLES) @(posedge clk);
      end
      if (p != 3) begin
        in_tvalid <= 0;
        repeat (SETTLE_CYCLES) @(posedge clk);
      end
      phase_regs(p, regs);
      program_regs(regs);
      sent = 0;
      if (p == 0) begin
        foreach (edge_z[i]) send_step(edge_z[i], i == 7);
        send_step(16'h7FFF, 1);
        send_step(16'h8000, 1);
        sent = 10;
      end
      if (p == 9) begin
        // Receiver holds off while one-step paths keep arriving.
        long_hold = 1;
        for (int i = 0; i < 12; i++) send_step(draw_sample(), 1);
        sent += 12;
      end
      while (sent < STEPS_PER_PHASE) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
        if (len > STEPS_PER_PHASE - sent) len = STEPS_PER_PHASE - sent;
        for (int i = 0; i < len; i++)
          send_step(draw_sample(), (i == len - 1) && !(p == 2 && sent + len >= STEPS_PER_PHASE));
        sent += len;
      end
    end

    in_tvalid <= 0;
    while (sb.pending_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d time steps through %0d register settings, %0d path results checked.",
             sb.steps_seen, NUM_PHASES, sb.results_seen);
    $display("Covered all payoff kinds, antithetic pairs, extreme samples and registers.");
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
